@@ sv/sfsd_pkg.sv @@
`timescale 1ns / 1ps

package sfsd_pkg;

   localparam int NUM_COMP   = 3;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;
   localparam int POS_W      = 13;

   localparam logic [1:0] FUNC_INDEX_LOAD = 2'd0;
   localparam logic [1:0] FUNC_LEVEL_LOAD = 2'd1;
   localparam logic [1:0] FUNC_PIXEL      = 2'd2;

   localparam logic [1:0] REG_COLOR_BASE     = 2'd0;
   localparam logic [1:0] REG_SEGMENT_OFFSET = 2'd1;
   localparam logic [1:0] REG_SEGMENT_WIDTH  = 2'd2;

   localparam logic [10:0] COUNT_MAX = 11'd2047;

   typedef enum logic [1:0] {
      STG_EMPTY,
      STG_TABLE,
      STG_INDEX,
      STG_LEVEL
   } stage_type;

endpackage

@@ sv/serpentine_fs_dither_rgb_top.sv @@
// Floyd-Steinberg serpentine dither of RGB pixels into a palette code.
// req_*: one transaction per item. tuser selects index-table load, level-table load
// or pixel; tlast on a pixel closes the row segment and reverses the direction.
// rsp_*: one transaction per pixel (pixel_code, write_enable); table loads and
// unknown functions give none. csr_*: register writes, always ready.
// A pixel's result is registered after its index stage and its level stage.
// Table loads are taken one per cycle while no pixel holds the index or level stage.
// The error loop paces pixels: index-table read, level-table read, then the 7/16
// carry feeding the next pixel's index-table address, so no item is taken while a
// pixel is in its index stage. Reset: resets registers and control, then zeroes the
// three error rows, one column per cycle, all MAX_WIDTH + 2 columns (1026 at the
// default); req_tready stays low during that pass, csr writes are taken.
// Stall: a result waits in the output register while the next item is still
// taken; a pixel holds in its level stage until the output register is free.
// Tables are not cleared: a pixel must not reach an unwritten entry.
`timescale 1ns / 1ps

module serpentine_fs_dither_rgb_top
   import sfsd_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // red[7:0], green[15:8], blue[23:16], mask_on[24], table_component[26:25],
   // table_index[34:27], table_value[42:35], zero above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func[1:0]
   input  logic [1:0]            req_tuser,
   // last_in_row
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pixel_code[7:0], write_enable[8], zero above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [10:0]           csr_data
);

   localparam int ROW_LEN = MAX_WIDTH + 2;
   localparam int AW      = $clog2(ROW_LEN);

   // configuration
   logic [7:0]  base_ff;
   logic [9:0]  offset_ff;
   logic [10:0] width_ff;

   // error row clearing pass
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   // input stage
   stage_type     stage_ff, stage_in;
   logic [1:0]    func_ff;
   logic [7:0]    sample_ff [NUM_COMP];
   logic          mask_ff;
   logic          last_ff;
   logic [1:0]    tcomp_ff;
   logic [7:0]    tidx_ff;
   logic [7:0]    tval_ff;
   logic [AW-1:0] rd_addr_ff, wr_addr_ff;
   logic          rd_ok_ff, wr_ok_ff;

   // row position
   logic [10:0]      count_ff;
   logic             odd_ff;
   logic [POS_W-1:0] k_pos, off_pos, w_pos, rd_pos, wr_pos;
   logic             rd_pos_ok, wr_pos_ok;
   logic [AW-1:0]    rd_addr_now;

   // error stage
   logic          p3_valid_ff;
   logic          p3_last_ff;
   logic [AW-1:0] p3_rd_addr_ff, p3_wr_addr_ff;
   logic          p3_rd_ok_ff, p3_wr_ok_ff;

   // last written error row positions, for read-after-write bypass
   logic          fw_wr_valid_ff, fw_af_valid_ff, af_pend_ff;
   logic [AW-1:0] fw_wr_addr_ff, fw_af_addr_ff;
   logic          m_p3_wr, m_p3_af, m_fw_wr, m_fw_af;

   // output register
   logic       rsp_valid_ff;
   logic [7:0] code_ff;
   logic       we_ff;

   logic       req_accept, pix_accept, out_free, level_adv, p3_row_we;
   logic [7:0] idx_rd [NUM_COMP];

   assign req_accept = req_tvalid & req_tready;
   assign pix_accept = req_accept & (req_tuser == FUNC_PIXEL);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign level_adv  = (stage_ff == STG_LEVEL) && out_free;
   assign req_tready = !clr_busy_ff &&
                       (stage_ff == STG_EMPTY || stage_ff == STG_TABLE || level_adv);
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 9){1'b0}}, we_ff, code_ff};

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= 8'd0;
         offset_ff <= 10'd0;
         width_ff  <= 11'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_COLOR_BASE:     base_ff   <= csr_data[7:0];
            REG_SEGMENT_OFFSET: offset_ff <= csr_data[9:0];
            REG_SEGMENT_WIDTH:  width_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- clear pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(ROW_LEN - 1)) begin
            clr_busy_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
      end
   end

   // ---------------------------------------------------------------- stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= STG_EMPTY;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_comb begin
      stage_in = stage_ff;
      case (stage_ff)
         STG_EMPTY: stage_in = STG_EMPTY;
         STG_TABLE: stage_in = STG_EMPTY;
         STG_INDEX: stage_in = STG_LEVEL;
         STG_LEVEL: begin
            if (out_free) stage_in = STG_EMPTY;
         end
         default: stage_in = STG_EMPTY;
      endcase
      if (req_accept) begin
         if (req_tuser inside {FUNC_INDEX_LOAD, FUNC_LEVEL_LOAD}) begin
            stage_in = STG_TABLE;
         end else if (req_tuser == FUNC_PIXEL) begin
            stage_in = STG_INDEX;
         end else begin
            stage_in = STG_EMPTY;
         end
      end
   end

   // ---------------------------------------------------------------- positions
   // after-row-end position equals the read position in both directions
   assign k_pos   = POS_W'(count_ff);
   assign off_pos = POS_W'(offset_ff);
   assign w_pos   = POS_W'(width_ff);
   assign rd_pos  = odd_ff ? off_pos + w_pos - k_pos : off_pos + k_pos + POS_W'(1);
   assign wr_pos  = odd_ff ? rd_pos + POS_W'(1) : rd_pos - POS_W'(1);
   assign rd_pos_ok = !rd_pos[POS_W-1] &&
                      ({20'd0, rd_pos[POS_W-2:0]} < 32'(ROW_LEN));
   assign wr_pos_ok = !wr_pos[POS_W-1] &&
                      ({20'd0, wr_pos[POS_W-2:0]} < 32'(ROW_LEN));
   assign rd_addr_now = rd_pos_ok ? AW'(rd_pos[POS_W-2:0]) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 11'd0;
         odd_ff   <= 1'b0;
      end else if (pix_accept) begin
         if (req_tlast) begin
            count_ff <= 11'd0;
            odd_ff   <= ~odd_ff;
         end else if (count_ff != COUNT_MAX) begin
            count_ff <= count_ff + 11'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff      <= req_tuser;
         sample_ff[0] <= req_tdata[7:0];
         sample_ff[1] <= req_tdata[15:8];
         sample_ff[2] <= req_tdata[23:16];
         mask_ff      <= req_tdata[24];
         tcomp_ff     <= req_tdata[26:25];
         tidx_ff      <= req_tdata[34:27];
         tval_ff      <= req_tdata[42:35];
         last_ff      <= req_tlast;
         rd_addr_ff   <= rd_addr_now;
         wr_addr_ff   <= wr_pos_ok ? AW'(wr_pos[POS_W-2:0]) : '0;
         rd_ok_ff     <= rd_pos_ok;
         wr_ok_ff     <= wr_pos_ok;
      end
   end

   // ---------------------------------------------------------------- error stage
   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= level_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (level_adv) begin
         p3_last_ff    <= last_ff;
         p3_rd_addr_ff <= rd_addr_ff;
         p3_wr_addr_ff <= wr_addr_ff;
         p3_rd_ok_ff   <= rd_ok_ff;
         p3_wr_ok_ff   <= wr_ok_ff;
      end
   end

   assign p3_row_we = p3_valid_ff && p3_wr_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_wr_valid_ff <= 1'b0;
         fw_af_valid_ff <= 1'b0;
         af_pend_ff     <= 1'b0;
      end else begin
         af_pend_ff <= p3_valid_ff && p3_last_ff && p3_rd_ok_ff;
         if (p3_valid_ff) begin
            fw_wr_valid_ff <= p3_wr_ok_ff;
            fw_af_valid_ff <= p3_last_ff && p3_rd_ok_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p3_valid_ff) begin
         fw_wr_addr_ff <= p3_wr_addr_ff;
         fw_af_addr_ff <= p3_rd_addr_ff;
      end
   end

   // newest write wins: the pixel in the error stage, then the one before it
   assign m_p3_wr = p3_row_we && (p3_wr_addr_ff == rd_addr_ff);
   assign m_p3_af = p3_valid_ff && p3_last_ff && p3_rd_ok_ff &&
                    (p3_rd_addr_ff == rd_addr_ff);
   assign m_fw_wr = fw_wr_valid_ff && (fw_wr_addr_ff == rd_addr_ff);
   assign m_fw_af = fw_af_valid_ff && (fw_af_addr_ff == rd_addr_ff);

   // ---------------------------------------------------------------- per component
   for (genvar c = 0; c < NUM_COMP; c++) begin : gen_comp
      logic signed [15:0] row_mem [ROW_LEN];
      logic [7:0]         idx_mem [256];
      logic [7:0]         lvl_mem [256];

      logic signed [15:0] row_rd_ff;
      logic [7:0]         idx_rd_ff;
      logic [7:0]         lvl_rd_ff;
      logic [7:0]         cur_ff;
      logic [7:0]         p3_cur_ff;
      logic signed [11:0] carry_ff;
      logic signed [9:0]  below_ff;
      logic signed [11:0] bprev_ff;
      logic signed [15:0] fw_wr_val_ff;
      logic signed [15:0] fw_af_val_ff;

      logic signed [9:0]  err;
      logic signed [12:0] err13;
      logic signed [11:0] err12;
      logic signed [12:0] wr_val;
      logic signed [11:0] nbprev;
      logic signed [11:0] carry_now;
      logic signed [11:0] carry_eff;
      logic signed [15:0] row_eff;
      logic signed [17:0] sum;
      logic signed [17:0] adj;
      logic [7:0]         cur_next;

      logic               row_we;
      logic [AW-1:0]      row_wa;
      logic signed [15:0] row_wd;

      assign idx_rd[c] = idx_rd_ff;

      // error of the pixel in the error stage and its spread
      assign err       = $signed({2'b00, p3_cur_ff}) - $signed({2'b00, lvl_rd_ff});
      assign err13     = 13'(err);
      assign err12     = 12'(err);
      assign wr_val    = 13'(bprev_ff) + err13 + (err13 <<< 1);
      assign nbprev    = 12'(below_ff) + err12 + (err12 <<< 2);
      assign carry_now = (err12 <<< 3) - err12;

      // rounded error plus sample, clamped; carry bypassed from the error stage
      assign carry_eff = p3_valid_ff ? (p3_last_ff ? 12'sd0 : carry_now) : carry_ff;

      always_comb begin
         if (!rd_ok_ff) begin
            row_eff = 16'sd0;
         end else if (m_p3_wr) begin
            row_eff = 16'(wr_val);
         end else if (m_p3_af) begin
            row_eff = 16'(nbprev);
         end else if (m_fw_wr) begin
            row_eff = fw_wr_val_ff;
         end else if (m_fw_af) begin
            row_eff = fw_af_val_ff;
         end else begin
            row_eff = row_rd_ff;
         end
      end

      assign sum = 18'(carry_eff) + 18'(row_eff) + 18'sd8;
      assign adj = (sum >>> 4) + $signed({10'd0, sample_ff[c]});

      always_comb begin
         if (adj[17]) begin
            cur_next = 8'd0;
         end else if (|adj[16:8]) begin
            cur_next = 8'd255;
         end else begin
            cur_next = adj[7:0];
         end
      end

      // error row write port: clearing, pixel write, then delayed row-end write
      always_comb begin
         row_we = clr_busy_ff || p3_row_we || af_pend_ff;
         if (clr_busy_ff) begin
            row_wa = clr_addr_ff;
            row_wd = 16'sd0;
         end else if (p3_row_we) begin
            row_wa = p3_wr_addr_ff;
            row_wd = 16'(wr_val);
         end else begin
            row_wa = fw_af_addr_ff;
            row_wd = fw_af_val_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (row_we) begin
            row_mem[row_wa] <= row_wd;
         end
         if (pix_accept) begin
            row_rd_ff <= row_mem[rd_addr_now];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ff == STG_TABLE && func_ff == FUNC_INDEX_LOAD && tcomp_ff == 2'(c)) begin
            idx_mem[tidx_ff] <= tval_ff;
         end
         if (stage_ff == STG_INDEX) begin
            idx_rd_ff <= idx_mem[cur_next];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ff == STG_TABLE && func_ff == FUNC_LEVEL_LOAD && tcomp_ff == 2'(c)) begin
            lvl_mem[tidx_ff] <= tval_ff;
         end
         if (level_adv) begin
            lvl_rd_ff <= lvl_mem[idx_rd_ff];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ff == STG_INDEX) begin
            cur_ff <= cur_next;
         end
         if (level_adv) begin
            p3_cur_ff <= cur_ff;
         end
         if (p3_valid_ff) begin
            fw_wr_val_ff <= 16'(wr_val);
            fw_af_val_ff <= 16'(nbprev);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            carry_ff <= 12'sd0;
            below_ff <= 10'sd0;
            bprev_ff <= 12'sd0;
         end else if (p3_valid_ff) begin
            if (p3_last_ff) begin
               carry_ff <= 12'sd0;
               below_ff <= 10'sd0;
               bprev_ff <= 12'sd0;
            end else begin
               carry_ff <= carry_now;
               below_ff <= err;
               bprev_ff <= nbprev;
            end
         end
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (level_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (level_adv) begin
         code_ff <= base_ff + idx_rd[0] + idx_rd[1] + idx_rd[2];
         we_ff   <= mask_ff;
      end
   end

endmodule
